### rtl/core/rbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_pkg
// Types and constants for the circular-buffer deque: depth, widths, operation
// and status codes, and the item formats at the ports and between the blocks.
// ----------------------------------------------------------------------------
package rbd_pkg;

    localparam int DEPTH     = 16;
    localparam int IDX_BITS  = $clog2(DEPTH);
    localparam int CNT_BITS  = $clog2(DEPTH + 1);
    localparam int WORD_BITS = 32;
    localparam int OP_BITS   = 3;
    localparam int CAP_BITS  = 5;

    localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(DEPTH);

    localparam logic [OP_BITS-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_BITS-1:0] OP_PUSH_REAR  = 3'd1;
    localparam logic [OP_BITS-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_BITS-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_BITS-1:0] OP_DUMP       = 3'd4;

    typedef enum logic [1:0] {
        ST_VALID     = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        K_PUSH_FRONT,
        K_PUSH_REAR,
        K_POP_FRONT,
        K_POP_BACK,
        K_DUMP
    } t_kind;

    typedef enum logic {
        S_RUN,
        S_DUMP
    } t_state;

    typedef struct packed {
        logic [OP_BITS-1:0]   operation;
        logic [WORD_BITS-1:0] data_value;
    } t_cmd;

    typedef struct packed {
        t_status              status;
        logic [WORD_BITS-1:0] data_word;
        logic                 last_of_run;
    } t_res;

    typedef struct packed {
        t_kind                kind;
        logic [WORD_BITS-1:0] data;
    } t_job;

    typedef struct packed {
        logic valid;
        logic ready;
    } t_link;

endpackage

### rtl/core/rbd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_front
// Command intake: accepts items, decodes the operation into a job kind, drops
// unused codes and hands jobs to the job queue.
// ----------------------------------------------------------------------------
module rbd_front import rbd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    output logic  busy,
    input  t_cmd  i_cmd,
    output t_link o_link,
    input  logic  i_link_ready,
    output t_job  o_job
);

    logic r_valid;
    logic n_valid;
    t_job r_job;
    t_job n_job;
    logic w_accept;
    logic w_legal;
    logic w_hand;

    assign busy     = r_valid && !i_link_ready;
    assign w_accept = start && !busy;
    assign w_hand   = r_valid && i_link_ready;

    always_comb begin
        w_legal    = 1'b1;
        n_job.data = i_cmd.data_value;
        unique case (i_cmd.operation)
            OP_PUSH_FRONT: n_job.kind = K_PUSH_FRONT;
            OP_PUSH_REAR:  n_job.kind = K_PUSH_REAR;
            OP_POP_FRONT:  n_job.kind = K_POP_FRONT;
            OP_POP_BACK:   n_job.kind = K_POP_BACK;
            OP_DUMP:       n_job.kind = K_DUMP;
            default: begin
                n_job.kind = K_DUMP;
                w_legal    = 1'b0;
            end
        endcase
    end

    assign n_valid = (r_valid && !w_hand) || (w_accept && w_legal);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (w_accept && w_legal) begin
            r_job <= n_job;
        end
    end

    assign o_link.valid = r_valid;
    assign o_link.ready = i_link_ready;
    assign o_job        = r_job;

endmodule

### rtl/core/rbd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_fifo
// Two-entry job queue between intake and execution.
// ----------------------------------------------------------------------------
module rbd_fifo import rbd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_link i_wr_link,
    output logic  o_wr_ready,
    input  t_job  i_job,
    output logic  o_rd_valid,
    input  logic  i_rd_take,
    output t_job  o_job
);

    t_job       r_slot [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_wr_ready = (r_cnt != 2'd2);
    assign o_rd_valid = (r_cnt != 2'd0);
    assign w_push     = i_wr_link.valid && o_wr_ready;
    assign w_pop      = i_rd_take && o_rd_valid;
    assign o_job      = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wptr <= !r_wptr;
            end
            if (w_pop) begin
                r_rptr <= !r_rptr;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
        if (w_push) begin
            r_slot[r_wptr] <= i_job;
        end
    end

endmodule

### rtl/core/rbd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_back
// Job execution: holds the circular store, the end indexes, the count and the
// capacity register; runs pushes, pops and dump sweeps and forms result items.
// ----------------------------------------------------------------------------
module rbd_back import rbd_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    output logic                o_job_take,
    input  t_job                i_job,
    input  logic                i_cfg_valid,
    input  logic [CAP_BITS-1:0] i_cfg_data,
    output logic                o_res_strobe,
    output t_res                o_res
);

    logic [WORD_BITS-1:0] r_mem [DEPTH];

    t_state               r_state;
    t_state               n_state;
    logic [CAP_BITS-1:0]  r_capacity;
    logic [IDX_BITS-1:0]  r_front;
    logic [IDX_BITS-1:0]  n_front;
    logic [IDX_BITS-1:0]  r_back;
    logic [IDX_BITS-1:0]  n_back;
    logic [CNT_BITS-1:0]  r_count;
    logic [CNT_BITS-1:0]  n_count;
    logic [IDX_BITS-1:0]  r_dump_addr;
    logic [IDX_BITS-1:0]  n_dump_addr;
    logic [CNT_BITS-1:0]  r_dump_left;
    logic [CNT_BITS-1:0]  n_dump_left;

    logic                 r_s1_valid;
    logic                 n_s1_valid;
    t_status              r_s1_status;
    t_status              n_s1_status;
    logic                 r_s1_last;
    logic                 n_s1_last;
    logic [WORD_BITS-1:0] r_rd_data;

    logic                 r_res_valid;
    t_res                 r_res;

    logic                 w_rd_en;
    logic [IDX_BITS-1:0]  w_rd_addr;
    logic                 w_wr_en;
    logic [IDX_BITS-1:0]  w_wr_addr;
    logic [CNT_BITS-1:0]  w_cap;
    logic                 w_full;
    logic                 w_empty;
    logic                 w_take;

    function automatic logic [IDX_BITS-1:0] f_inc(input logic [IDX_BITS-1:0] idx,
                                                  input logic [CNT_BITS-1:0] cap);
        logic [CNT_BITS-1:0] nxt;
        nxt = {1'b0, idx} + CNT_BITS'(1);
        return (nxt == cap) ? '0 : nxt[IDX_BITS-1:0];
    endfunction

    function automatic logic [IDX_BITS-1:0] f_dec(input logic [IDX_BITS-1:0] idx,
                                                  input logic [CNT_BITS-1:0] cap);
        logic [CNT_BITS-1:0] top;
        top = cap - CNT_BITS'(1);
        return (idx == '0) ? top[IDX_BITS-1:0] : idx - IDX_BITS'(1);
    endfunction

    assign w_cap   = (r_capacity > CAP_BITS'(DEPTH)) ? CNT_BITS'(DEPTH)
                                                     : CNT_BITS'(r_capacity);
    assign w_full  = (w_cap == '0) || (r_count >= w_cap);
    assign w_empty = (r_count == '0) || (w_cap == '0);
    assign w_take  = (r_state == S_RUN) && i_job_valid;
    assign o_job_take = (r_state == S_RUN);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_RUN: begin
                if (w_take && i_job.kind == K_DUMP && !w_empty
                        && r_count != CNT_BITS'(1)) begin
                    n_state = S_DUMP;
                end
            end
            S_DUMP: begin
                if (r_dump_left == CNT_BITS'(1)) begin
                    n_state = S_RUN;
                end
            end
            default: n_state = S_RUN;
        endcase
    end

    always_comb begin
        n_front     = r_front;
        n_back      = r_back;
        n_count     = r_count;
        n_dump_addr = r_dump_addr;
        n_dump_left = r_dump_left;
        n_s1_valid  = 1'b0;
        n_s1_status = ST_VALID;
        n_s1_last   = 1'b1;
        w_rd_en     = 1'b0;
        w_rd_addr   = r_front;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_back;
        unique case (r_state)
            S_RUN: begin
                if (w_take) begin
                    unique case (i_job.kind)
                        K_PUSH_FRONT, K_PUSH_REAR: begin
                            if (w_full) begin
                                n_s1_valid  = 1'b1;
                                n_s1_status = ST_OVERFLOW;
                            end else begin
                                w_wr_en = 1'b1;
                                n_count = r_count + CNT_BITS'(1);
                                if (i_job.kind == K_PUSH_FRONT) begin
                                    w_wr_addr = f_dec(r_front, w_cap);
                                    n_front   = w_wr_addr;
                                end else begin
                                    w_wr_addr = r_back;
                                    n_back    = f_inc(r_back, w_cap);
                                end
                            end
                        end
                        K_POP_FRONT, K_POP_BACK: begin
                            n_s1_valid = 1'b1;
                            if (w_empty) begin
                                n_s1_status = ST_UNDERFLOW;
                            end else begin
                                w_rd_en = 1'b1;
                                n_count = r_count - CNT_BITS'(1);
                                if (i_job.kind == K_POP_FRONT) begin
                                    w_rd_addr = r_front;
                                    n_front   = f_inc(r_front, w_cap);
                                end else begin
                                    w_rd_addr = f_dec(r_back, w_cap);
                                    n_back    = w_rd_addr;
                                end
                            end
                        end
                        K_DUMP: begin
                            n_s1_valid = 1'b1;
                            if (w_empty) begin
                                n_s1_status = ST_EMPTY;
                            end else begin
                                w_rd_en     = 1'b1;
                                w_rd_addr   = r_front;
                                n_s1_last   = (r_count == CNT_BITS'(1));
                                n_dump_addr = f_inc(r_front, w_cap);
                                n_dump_left = r_count - CNT_BITS'(1);
                            end
                        end
                        default: begin
                            n_s1_valid = 1'b0;
                        end
                    endcase
                end
            end
            S_DUMP: begin
                w_rd_en     = 1'b1;
                w_rd_addr   = r_dump_addr;
                n_s1_valid  = 1'b1;
                n_s1_last   = (r_dump_left == CNT_BITS'(1));
                n_dump_addr = f_inc(r_dump_addr, w_cap);
                n_dump_left = r_dump_left - CNT_BITS'(1);
            end
            default: begin
                n_s1_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= i_job.data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_capacity  <= CAP_RESET;
            r_front     <= '0;
            r_back      <= '0;
            r_count     <= '0;
            r_dump_addr <= '0;
            r_dump_left <= '0;
            r_s1_valid  <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_dump_addr <= n_dump_addr;
            r_dump_left <= n_dump_left;
            r_s1_valid  <= n_s1_valid;
            r_res_valid <= r_s1_valid;
            if (i_cfg_valid) begin
                r_capacity <= i_cfg_data;
                r_front    <= '0;
                r_back     <= '0;
                r_count    <= '0;
            end else begin
                r_front    <= n_front;
                r_back     <= n_back;
                r_count    <= n_count;
            end
        end
        r_s1_status       <= n_s1_status;
        r_s1_last         <= n_s1_last;
        r_res.status      <= r_s1_status;
        r_res.last_of_run <= r_s1_last;
        r_res.data_word   <= (r_s1_status == ST_VALID) ? r_rd_data : '0;
    end

    assign o_res_strobe = r_res_valid;
    assign o_res        = r_res;

endmodule

### rtl/core/ring_buffer_deque_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_buffer_deque_top
// Double-ended queue of 32-bit words on a 16-entry circular store.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Push and pop do not
// hold the execution unit, so they sustain one item per clock unless a dump
// holds it until it has read out every stored word; busy rises once the
// two-entry job queue behind the intake register fills. With no dump ahead,
// a result passes the intake register, the job queue, the read stage and the
// result register before it rises on o_res with o_res_strobe; dump words
// follow on consecutive cycles. Results cannot be held off, so they must be
// captured on the strobe. Writing the capacity empties the queue and is only
// legal while no item is in flight; cfg ready stays high.
// ----------------------------------------------------------------------------
module ring_buffer_deque_top import rbd_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  t_cmd                i_cmd,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CAP_BITS-1:0] i_cfg_data,
    output logic                o_res_strobe,
    output t_res                o_res
);

    t_link w_link;
    t_job  w_front_job;
    t_job  w_queue_job;
    logic  w_queue_ready;
    logic  w_queue_valid;
    logic  w_take;

    assign o_cfg_ready = 1'b1;

    rbd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .o_link       (w_link),
        .i_link_ready (w_queue_ready),
        .o_job        (w_front_job)
    );

    rbd_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_link  (w_link),
        .o_wr_ready (w_queue_ready),
        .i_job      (w_front_job),
        .o_rd_valid (w_queue_valid),
        .i_rd_take  (w_take),
        .o_job      (w_queue_job)
    );

    rbd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (w_queue_valid),
        .o_job_take   (w_take),
        .i_job        (w_queue_job),
        .i_cfg_valid  (i_cfg_valid && o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_res_strobe (o_res_strobe),
        .o_res        (o_res)
    );

endmodule

### rtl/core/rbd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_checker
// Port-level checks on the deque result stream, bound to the top level.
// ----------------------------------------------------------------------------
module rbd_checker import rbd_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_res_strobe,
    input t_res o_res
);

    a_status_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && o_res.status != ST_VALID) |-> o_res.last_of_run)
        else $error("status result without last_of_run");

    a_status_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && o_res.status != ST_VALID) |-> (o_res.data_word == '0))
        else $error("status result carries data");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && !o_res.last_of_run) |=> (o_res_strobe && o_res.status == ST_VALID))
        else $error("dump run broken");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_strobe)
        else $error("result strobe after reset");

endmodule

bind ring_buffer_deque_top rbd_checker u_rbd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_res_strobe (o_res_strobe),
    .o_res        (o_res)
);
